/* hdl/gmiu_pkg.sv */
// Shared types and field widths for the graded multi-index unrank core.
// Used by the top level and the port checker.
`default_nettype none
package gmiu_pkg;

  // Fixed widths of the stream fields
  localparam int RANK_W     = 16;
  localparam int DEG_W      = 16;
  localparam int POS_W      = 3;
  localparam int DIMS_W     = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PEEL  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_EMIT  = 5'b10000
  } gmiu_state_e;

endpackage
`default_nettype wire

/* hdl/gmiu_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
// Standalone; used by graded_multi_index_unrank_core for the binomial update.
`default_nettype none
module gmiu_divider #(
  parameter int DW = 20,
  parameter int VW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q, div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   shifted, diff;
  logic          ge;

  // trial subtract of the next partial remainder
  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = (shifted >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        quo_q  <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
        cnt_q  <= CW'(DW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        quo_q <= {quo_q[DW-2:0], ge};
        rem_q <= ge ? diff[VW-1:0] : shifted[VW-1:0];
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

/* hdl/graded_multi_index_unrank_core.sv */
// Graded multi-index unrank core: rank in, one degree per dimension out.
// Depends on gmiu_pkg and gmiu_divider.
//
// Usage:
//   s_axis carries one rank per item (tdata[15:0]). m_axis returns one item
//   per dimension, in dimension order; tdata[15:0] is the degree,
//   tdata[18:16] the dimension number, tlast marks the final dimension.
//   dims_wr_en_i/dims_wr_data_i set the dimension count while idle; 0 acts
//   as 1 and values above MAX_DIMS act as MAX_DIMS.
// Timing:
//   One rank at a time; s_axis_tready is high only when idle. Each degree
//   search step costs one multiply plus a bit-serial divide, and a final
//   check closes each search.
//   A search takes as many steps as the degree found (a few hundred at most
//   for 16-bit ranks with two dimensions), and there is one search per
//   dimension except the last.
//   A zero rank or a single dimension needs no search.
// Reset clears the sequencer and sets the dimension count to 1.
// A stall on m_axis holds the current item and pauses the sequencer.
`default_nettype none
module graded_multi_index_unrank_core
  import gmiu_pkg::*;
#(
  parameter int MAX_DIMS  = 8,
  parameter int RANK_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  dims_wr_en_i,
  input  wire logic [DIMS_W-1:0]     dims_wr_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] rank
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [15:0] degree, [18:16] position
  output logic                       m_axis_tlast    // last component
);

  localparam int RB   = RANK_BITS;
  localparam int DIMW = $clog2(MAX_DIMS + 1);
  localparam int IW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DW   = RB + DIMW;
  localparam int CW   = (DIMW > DIMS_W) ? DIMW : DIMS_W;

  gmiu_state_e     state_q, state_d;
  logic [DIMS_W-1:0] dims_q;
  logic [RB-1:0]   cur_q, lower_q, deg_q, idx_q, n_q, prev_q;
  logic [DW-1:0]   b_q;
  logic [DIMW-1:0] d_q, ds_q;
  logic [IW-1:0]   i_q;
  logic            first_q, stop_q;
  logic [DEG_W-1:0] out_deg_q;
  logic [POS_W-1:0] out_pos_q;
  logic            out_last_q;

  logic [RB+RANK_W-1:0] rank_ext;
  logic [RB-1:0]        rank_v;
  logic [CW-1:0]        dims_ext;
  logic [DIMW-1:0]      d_eff, ds_next;
  logic                 last_i;
  logic [RB-1:0]        cur_diff;
  logic [RB-1:0]        deg_val;
  logic [IW+POS_W-1:0]  pos_ext;
  logic                 div_start, div_done;
  logic [DW-1:0]        div_quo, prod;
  logic                 in_acc;

  // low bits of a degree for the output field
  function automatic logic [DEG_W-1:0] deg_ext_f(input logic [RB-1:0] v);
    logic [RB+DEG_W-1:0] e;
    e = {{DEG_W{1'b0}}, v};
    return e[DEG_W-1:0];
  endfunction

  // input rank restricted to RANK_BITS
  assign rank_ext = {{RB{1'b0}}, s_axis_tdata[RANK_W-1:0]};
  assign rank_v   = rank_ext[RB-1:0];

  // clamp the configured dimension count
  always_comb begin
    dims_ext = CW'(dims_q);
    if (dims_ext == '0) begin
      d_eff = DIMW'(1);
    end else if (dims_ext > CW'(MAX_DIMS)) begin
      d_eff = DIMW'(MAX_DIMS);
    end else begin
      d_eff = dims_ext[DIMW-1:0];
    end
  end

  assign last_i   = ((DIMW'(i_q) + DIMW'(1)) == d_q);
  assign ds_next  = d_q - DIMW'(i_q) - DIMW'(1);
  assign cur_diff = cur_q - lower_q;
  assign pos_ext  = {{POS_W{1'b0}}, i_q};
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // shared multiply feeding the divider: b * d for the binomial update
  assign prod      = DW'(b_q[RB-1:0]) * DW'(ds_q);
  assign div_start = (state_q == ST_CHECK) && (b_q <= DW'(idx_q));

  gmiu_divider #(
    .DW(DW),
    .VW(RB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (n_q + RB'(1)),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (rank_v == '0 || d_eff == DIMW'(1)) state_d = ST_PEEL;
          else state_d = ST_CHECK;
        end
      end
      ST_PEEL: begin
        if (last_i || stop_q || cur_q <= lower_q || ds_next == DIMW'(1)) state_d = ST_EMIT;
        else state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (div_start) state_d = ST_DIV;
        else if (first_q) state_d = ST_PEEL;
        else state_d = ST_EMIT;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_CHECK;
      end
      ST_EMIT: begin
        if (m_axis_tready) state_d = out_last_q ? ST_IDLE : ST_PEEL;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      dims_q     <= DIMS_W'(1);
      i_q        <= '0;
      first_q    <= 1'b0;
      stop_q     <= 1'b0;
      out_last_q <= 1'b0;
      out_deg_q  <= '0;
      out_pos_q  <= '0;
      d_q        <= DIMW'(1);
      ds_q       <= '0;
      cur_q      <= '0;
      lower_q    <= '0;
      deg_q      <= '0;
      idx_q      <= '0;
      n_q        <= '0;
      prev_q     <= RB'(1);
      b_q        <= DW'(1);
    end else begin
      state_q <= state_d;
      if (dims_wr_en_i) begin
        dims_q <= dims_wr_data_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            d_q     <= d_eff;
            i_q     <= '0;
            cur_q   <= rank_v;
            stop_q  <= (rank_v == '0);
            deg_q   <= rank_v;
            lower_q <= rank_v;
            idx_q   <= rank_v;
            ds_q    <= d_eff;
            n_q     <= '0;
            b_q     <= DW'(1);
            prev_q  <= RB'(1);
            first_q <= 1'b1;
          end
        end
        ST_PEEL: begin
          out_pos_q  <= pos_ext[POS_W-1:0];
          out_last_q <= last_i;
          if (last_i) begin
            out_deg_q <= stop_q ? '0 : deg_ext_f(deg_val);
          end else if (stop_q) begin
            out_deg_q <= '0;
          end else if (cur_q <= lower_q) begin
            out_deg_q <= deg_ext_f(deg_val);
            stop_q    <= 1'b1;
          end else begin
            cur_q <= cur_diff;
            if (ds_next == DIMW'(1)) begin
              out_deg_q <= deg_ext_f(deg_q - cur_diff);
              deg_q     <= cur_diff;
              lower_q   <= cur_diff;
            end else begin
              idx_q   <= cur_diff;
              ds_q    <= ds_next;
              n_q     <= '0;
              b_q     <= DW'(1);
              prev_q  <= RB'(1);
              first_q <= 1'b0;
            end
          end
        end
        ST_CHECK: begin
          if (div_start) begin
            n_q    <= n_q + RB'(1);
            prev_q <= b_q[RB-1:0];
          end else begin
            lower_q <= prev_q;
            deg_q   <= n_q;
            if (!first_q) begin
              out_deg_q <= deg_ext_f(deg_q - n_q);
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            b_q <= b_q + div_quo;
          end
        end
        ST_EMIT: begin
          if (m_axis_tready && !out_last_q) begin
            i_q <= i_q + IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign deg_val = deg_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tdata  = {{(OUT_DATA_W - DEG_W - POS_W){1'b0}}, out_pos_q, out_deg_q};
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

/* hdl/gmiu_port_checker.sv */
// Port-level checks for graded_multi_index_unrank_core, with its bind.
// Depends on gmiu_pkg.
`default_nettype none
module gmiu_port_checker
  import gmiu_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tlast
);

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // never take a rank while a result is waiting
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output pending");

  // an accepted rank never yields a result in the next cycle
  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result appeared too early");

  // the first component after a finished rank is dimension zero
  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 !m_axis_tvalid
      || m_axis_tdata[18:16] == 3'd0)
    else $error("component numbering did not restart");

endmodule

bind graded_multi_index_unrank_core gmiu_port_checker u_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for graded_multi_index_unrank_core: ranks in, one degree per dimension out.
// Depends on gmiu_pkg and the core RTL; an internal unranking predictor builds the expected items.
`default_nettype none
module tb_top
  import gmiu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIMS   = 8;
  localparam int QUIET_MAX  = 200000;

  typedef struct packed {
    logic [DEG_W-1:0] degree;
    logic [POS_W-1:0] position;
    logic             last;
  } component_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  dims_wr_en_i = 1'b0;
  logic [DIMS_W-1:0]     dims_wr_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  logic [RANK_W-1:0] rank_q[$];       // ranks waiting to be sent
  component_t        component_q[$];  // predicted components, oldest first
  logic [DIMS_W-1:0] dims_shadow = 4'd1;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                mismatches = 0;
  int                ranks_sent = 0;
  int                components_seen = 0;
  int                quiet_cycles = 0;

  graded_multi_index_unrank_core #(
    .MAX_DIMS  (MAX_DIMS),
    .RANK_BITS (16)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dims_wr_en_i   (dims_wr_en_i),
    .dims_wr_data_i (dims_wr_data_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),   // [15:0] rank
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),   // [15:0] degree, [18:16] position
    .m_axis_tlast   (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Smallest n with C(n+d,n) > idx; lower gets C(n-1+d,n-1)
  function automatic longint unsigned find_degree(longint unsigned idx, longint unsigned d,
                                                  output longint unsigned lower);
    longint unsigned n, b, prev;
    n = 0;
    b = 1;
    prev = 1;
    if (d == 1) begin
      lower = (idx == 0) ? 1 : idx;
      return idx;
    end
    while (b <= idx) begin
      n++;
      prev = b;
      b = b + (b * d) / n;
    end
    lower = prev;
    return n;
  endfunction

  // Unrank one value and queue one component per dimension
  function automatic void predict_components(logic [RANK_W-1:0] rank, logic [DIMS_W-1:0] dims);
    longint unsigned d, cur, deg, rest, lower;
    longint unsigned comp[MAX_DIMS];
    bit stopped;
    component_t c;
    d = dims;
    if (d == 0) d = 1;
    if (d > MAX_DIMS) d = MAX_DIMS;
    foreach (comp[k]) comp[k] = 0;
    cur = rank;
    stopped = 0;
    if (cur != 0) begin
      deg = find_degree(cur, d, lower);
      for (int i = 0; i + 1 < d; i++) begin
        if (cur <= lower) begin
          comp[i] = deg;
          stopped = 1;
          break;
        end
        cur -= lower;
        rest = find_degree(cur, d - i - 1, lower);
        comp[i] = deg - rest;
        deg = rest;
      end
      if (!stopped) comp[d-1] = deg;
    end
    for (int k = 0; k < d; k++) begin
      c.degree   = comp[k][DEG_W-1:0];
      c.position = k[POS_W-1:0];
      c.last     = (k + 1 == d);
      component_q.push_back(c);
    end
  endfunction

  // Driver: predict on acceptance, then present the next rank or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_components(s_axis_tdata[RANK_W-1:0], dims_shadow);
        ranks_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rank_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rank_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each item with the oldest prediction
  always @(posedge clk_i) begin
    component_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        components_seen++;
        if (component_q.size() == 0) begin
          $error("unexpected item: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = component_q.pop_front();
          if (m_axis_tdata[15:0] !== want.degree) begin
            $error("component_degree: expected %0d, got %0d", want.degree, m_axis_tdata[15:0]);
            mismatches++;
          end
          if (m_axis_tdata[18:16] !== want.position) begin
            $error("component_position: expected %0d, got %0d", want.position,
                   m_axis_tdata[18:16]);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_component: expected %0b, got %0b", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no item moving either way
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (rank_q.size() != 0 || s_axis_tvalid || component_q.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_dims(logic [DIMS_W-1:0] value);
    wait_idle();
    @(posedge clk_i);
    dims_wr_en_i   <= 1'b1;
    dims_wr_data_i <= value;
    @(posedge clk_i);
    dims_wr_en_i   <= 1'b0;
    dims_shadow = value;
  endtask

  // Mostly small ranks so the degree search stays short
  function automatic logic [RANK_W-1:0] random_rank();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return RANK_W'($urandom_range(0, 255));
    if (sel < 85) return RANK_W'($urandom_range(0, 4095));
    return RANK_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset dimension count of one, then extremes and clamping
    rank_q = '{16'd0, 16'd1, 16'hffff, 16'h5555};
    set_dims(4'd2);
    rank_q = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'hffff};
    set_dims(4'd8);
    rank_q = '{16'd0, 16'd1, 16'd9, 16'd100, 16'hffff};
    set_dims(4'd0);
    rank_q = '{16'd7, 16'haaaa};
    set_dims(4'd15);
    rank_q = '{16'd0, 16'd1, 16'd300, 16'h8000};

    // Random: three idling profiles, dimension count changed every chunk
    for (int mode = 0; mode < 3; mode++) begin
      for (int chunk = 0; chunk < 5; chunk++) begin
        set_dims(DIMS_W'($urandom_range(0, 15)));
        case (mode)
          0: begin send_idle_pct = 16; recv_stall_pct = 61; end
          1: begin send_idle_pct = 61; recv_stall_pct = 16; end
          default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
        for (int n = 0; n < 20; n++) rank_q.push_back(random_rank());
      end
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("Sent %0d ranks and checked %0d components over dimension counts 0..15,",
             ranks_sent, components_seen);
    $display("under three sender/receiver idling profiles; %0d mismatches.", mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
